// ----- src/tdse_pkg.sv -----
package tdse_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CUR_W      = 14;
    localparam int STATE_W    = 7;
    localparam int COUNT_W    = 8;
    localparam int GWIDTH_W   = 4;
    localparam int GVALUE_W   = 8;
    localparam int SYM_W      = 3;
    localparam int SUM_W      = 10;
    localparam int IDX_W      = 6;
    localparam int MAX_GROUPS = 4;
    localparam int NUM_W      = 3;
    localparam int SLOT_W     = 2;
    localparam int TDATA_OUT_W = 16;

    localparam logic [STATE_W-1:0]  STATE_LOW     = 7'd64;
    localparam logic [COUNT_W-1:0]  BLOCK_LEN_RST = 8'd7;
    localparam logic [SYM_W-1:0]    ESC_SYM       = 3'd7;
    localparam logic [SYM_W-1:0]    MAX_DELTA     = 3'd3;
    localparam logic [GWIDTH_W-1:0] RAW_LO_W      = 4'd8;
    localparam logic [GWIDTH_W-1:0] RAW_HI_W      = 4'd6;
    localparam logic [GWIDTH_W-1:0] STATE_BITS    = 4'd6;

    localparam logic [SUM_W-1:0] SYM_BIAS [8] = '{
        10'd704, 10'd704, 10'd416, 10'd34, 10'd416, 10'd704, 10'd704, 10'd704
    };

    localparam logic signed [7:0] SYM_OFFSET [8] = '{
        -8'sd1, 8'sd0, -8'sd4, -8'sd39, 8'sd49, 8'sd60, 8'sd61, 8'sd62
    };

    localparam logic [STATE_W-1:0] NEXT_STATE_ROM [64] = '{
        7'd127, 7'd124, 7'd64,  7'd72,  7'd81,  7'd90,  7'd99,  7'd108,
        7'd66,  7'd67,  7'd68,  7'd69,  7'd70,  7'd71,  7'd74,  7'd75,
        7'd76,  7'd77,  7'd78,  7'd79,  7'd80,  7'd83,  7'd84,  7'd85,
        7'd86,  7'd87,  7'd88,  7'd89,  7'd91,  7'd93,  7'd94,  7'd95,
        7'd96,  7'd97,  7'd98,  7'd100, 7'd102, 7'd103, 7'd104, 7'd105,
        7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd114, 7'd115,
        7'd116, 7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd65,
        7'd73,  7'd82,  7'd92,  7'd101, 7'd110, 7'd123, 7'd126, 7'd125
    };

    typedef struct packed {
        logic [GWIDTH_W-1:0] width;
        logic [GVALUE_W-1:0] value;
        logic                blk_end;
    } group_t;

    typedef struct packed {
        group_t [MAX_GROUPS-1:0] grp;
        logic [NUM_W-1:0]        num;
        logic [STATE_W-1:0]      state_next;
        logic [COUNT_W-1:0]      count_next;
    } step_out_t;

endpackage

// ----- src/tdse_step.sv -----
module tdse_step
(
    input  logic [tdse_pkg::SAMPLE_W-1:0] sample,
    input  logic [tdse_pkg::STATE_W-1:0]  coder_state,
    input  logic [tdse_pkg::CUR_W-1:0]    prev_sample,
    input  logic [tdse_pkg::COUNT_W-1:0]  sample_count,
    input  logic [tdse_pkg::COUNT_W-1:0]  block_length,
    output tdse_pkg::step_out_t           step_out
);

    logic [tdse_pkg::CUR_W-1:0]      cur;
    logic signed [tdse_pkg::CUR_W:0] diff;
    logic                            near;
    logic                            esc;
    logic [tdse_pkg::SYM_W-1:0]      sym;
    logic [tdse_pkg::SUM_W-1:0]      sum;
    logic [tdse_pkg::GWIDTH_W-1:0]   nbits;
    logic [tdse_pkg::GVALUE_W-1:0]   mask;
    logic [tdse_pkg::STATE_W-1:0]    shifted;
    logic [7:0]                      idx_sum;
    logic [tdse_pkg::STATE_W-1:0]    rom_state;
    logic [tdse_pkg::COUNT_W-1:0]    count_inc;
    logic                            blk_done;
    logic [tdse_pkg::NUM_W-1:0]      num;

    always_comb
    begin
        cur  = sample[tdse_pkg::SAMPLE_W-1:2];
        diff = $signed({1'b0, cur}) - $signed({1'b0, prev_sample});
        near = (diff >= -15'sd3) && (diff <= 15'sd3);
        esc  = (sample_count == '0) || !near;
        sym  = esc ? tdse_pkg::ESC_SYM : (diff[tdse_pkg::SYM_W-1:0] + tdse_pkg::MAX_DELTA);

        sum   = {3'b000, coder_state} + tdse_pkg::SYM_BIAS[sym];
        nbits = {1'b0, sum[tdse_pkg::SUM_W-1:7]};
        mask  = (nbits >= 4'd8) ? 8'hFF : ((8'd1 << nbits) - 8'd1);

        shifted   = coder_state >> nbits;
        idx_sum   = tdse_pkg::SYM_OFFSET[sym] + {1'b0, shifted};
        rom_state = tdse_pkg::NEXT_STATE_ROM[idx_sum[tdse_pkg::IDX_W-1:0]];

        count_inc = sample_count + 8'd1;
        blk_done  = (count_inc >= block_length) || (count_inc == '0);

        step_out = '0;
        step_out.grp[0].width = nbits;
        step_out.grp[0].value = {1'b0, coder_state} & mask;
        num = 3'd1;
        if (esc)
        begin
            step_out.grp[1].width = tdse_pkg::RAW_LO_W;
            step_out.grp[1].value = cur[7:0];
            step_out.grp[2].width = tdse_pkg::RAW_HI_W;
            step_out.grp[2].value = {2'b00, cur[tdse_pkg::CUR_W-1:8]};
            num = 3'd3;
        end
        if (blk_done)
        begin
            step_out.grp[num[tdse_pkg::SLOT_W-1:0]].width   = tdse_pkg::STATE_BITS;
            step_out.grp[num[tdse_pkg::SLOT_W-1:0]].value   = {2'b00, rom_state[5:0]};
            step_out.grp[num[tdse_pkg::SLOT_W-1:0]].blk_end = 1'b1;
            num = num + 3'd1;
        end
        step_out.num        = num;
        step_out.state_next = blk_done ? tdse_pkg::STATE_LOW : rom_state;
        step_out.count_next = blk_done ? '0 : count_inc;
    end

endmodule

// ----- src/tdse_serializer.sv -----
module tdse_serializer
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  tdse_pkg::step_out_t                  step_out,
    output logic                                 load_ready,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [tdse_pkg::TDATA_OUT_W-1:0]     m_tdata,  // group_width[3:0], group_value[11:4]
    output logic                                 m_tlast,
    output logic                                 m_tuser   // block_end
);

    tdse_pkg::group_t [tdse_pkg::MAX_GROUPS-1:0] grp_reg;
    logic [tdse_pkg::NUM_W-1:0]                  num_reg;
    logic [tdse_pkg::SLOT_W-1:0]                 slot_reg;
    logic [tdse_pkg::SLOT_W-1:0]                 slot_next;
    logic                                        valid_reg;
    logic                                        valid_next;
    logic                                        is_last;
    tdse_pkg::group_t                            cur_grp;

    always_comb
    begin
        cur_grp    = grp_reg[slot_reg];
        is_last    = ({1'b0, slot_reg} + 3'd1) == num_reg;
        load_ready = !valid_reg || (m_tready && is_last);
        valid_next = valid_reg;
        slot_next  = slot_reg;
        if (load)
        begin
            valid_next = 1'b1;
            slot_next  = '0;
        end
        else if (valid_reg && m_tready)
        begin
            if (is_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                slot_next = slot_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            slot_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= step_out.grp;
            num_reg <= step_out.num;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, cur_grp.value, cur_grp.width};
    assign m_tlast  = is_last;
    assign m_tuser  = cur_grp.blk_end;

endmodule

// ----- src/tans_delta_sample_encoder.sv -----
// A sample is captured in the input register and, once the serializer can take it, loaded
// into the serializer's group registers, from which its first group goes to the master side.
// Throughput: one group per cycle while m_tready is high; a sample gives 1 to 4 groups.
// A sample waits in the input register while the groups ahead of it drain, and a new sample
// is taken as soon as the sample ahead of it moves on into the serializer.
// Reset (rst_n low, asynchronous): pipeline empty, coder state 64, block count 0,
// previous sample 0, block_length 7.
module tans_delta_sample_encoder
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [tdse_pkg::SAMPLE_W-1:0]        s_tdata,  // sample[15:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [tdse_pkg::TDATA_OUT_W-1:0]     m_tdata,  // group_width[3:0], group_value[11:4]
    output logic                                 m_tlast,
    output logic                                 m_tuser,  // block_end
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tdse_pkg::COUNT_W-1:0]         cfg_data  // block_length
);

    logic                            in_valid_reg;
    logic                            in_valid_next;
    logic [tdse_pkg::SAMPLE_W-1:0]   in_sample_reg;
    logic [tdse_pkg::STATE_W-1:0]    coder_state_reg;
    logic [tdse_pkg::CUR_W-1:0]      prev_sample_reg;
    logic [tdse_pkg::COUNT_W-1:0]    sample_count_reg;
    logic [tdse_pkg::COUNT_W-1:0]    block_length_reg;
    logic                            load_ready;
    logic                            load;
    logic                            s_take;
    tdse_pkg::step_out_t             step_out;

    assign cfg_ready = 1'b1;
    assign load      = in_valid_reg && load_ready;
    assign s_tready  = !in_valid_reg || load_ready;
    assign s_take    = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            coder_state_reg  <= tdse_pkg::STATE_LOW;
            prev_sample_reg  <= '0;
            sample_count_reg <= '0;
            block_length_reg <= tdse_pkg::BLOCK_LEN_RST;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (load)
            begin
                coder_state_reg  <= step_out.state_next;
                prev_sample_reg  <= in_sample_reg[tdse_pkg::SAMPLE_W-1:2];
                sample_count_reg <= step_out.count_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                block_length_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_sample_reg <= s_tdata;
        end
    end

    tdse_step u_step
    (
        .sample       (in_sample_reg),
        .coder_state  (coder_state_reg),
        .prev_sample  (prev_sample_reg),
        .sample_count (sample_count_reg),
        .block_length (block_length_reg),
        .step_out     (step_out)
    );

    tdse_serializer u_ser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .step_out   (step_out),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ----- src/tdse_checker.sv -----
module tdse_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [tdse_pkg::TDATA_OUT_W-1:0]     m_tdata,
    input logic                                 m_tlast,
    input logic                                 m_tuser
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped under stall");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
        else $error("output transaction changed under stall");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("block end group not last of its sample");

    a_end_width: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[3:0] == 4'd6) && (m_tdata[11:10] == 2'b00))
        else $error("block end group has wrong width or value");

    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[3:0] <= 4'd8) && (m_tdata[15:12] == 4'd0))
        else $error("group width out of range or padding set");

endmodule

bind tans_delta_sample_encoder tdse_checker u_tdse_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
